@@ design/png_chunk_walker_crc_check_macros.svh @@
// assertion macros for the chunk walker
`ifndef PNG_CHUNK_WALKER_CRC_CHECK_MACROS_SVH
`define PNG_CHUNK_WALKER_CRC_CHECK_MACROS_SVH
// property that must hold whenever not in reset
`define PCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define PCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`endif

@@ design/pcw_pkg.sv @@
// ----------------------------------------------------------------------------
// pcw_pkg
// shared types and constants of the chunk walker
// ----------------------------------------------------------------------------
package pcw_pkg;
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [30:0] MAX_LEN = 31'h7FFFFFFF;
    localparam int HDR_BYTES = 13;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] chunk_offset;
        logic [30:0] chunk_length;
        logic [31:0] chunk_type;
        logic [31:0] crc_stored;
        logic [31:0] crc_computed;
        logic        crc_ok;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  bit_depth;
        logic [7:0]  color_type;
        logic [23:0] ihdr_methods;
        logic        truncated;
    } t_out_word;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  phase;
        logic        first;     // first byte of length field: start new chunk
        logic [3:0]  hdr_idx;   // header capture slot
        logic        hdr_cap;
        logic        emit;      // completes crc field
        logic        trunc;     // last byte of file inside a chunk
        logic [31:0] offset;
    } t_cmd;

    function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] a;
        a = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
        end
        return a;
    endfunction
endpackage

@@ design/pcw_front.sv @@
// ----------------------------------------------------------------------------
// pcw_front
// tracks phase and field counts, classifies each byte into a command
// ----------------------------------------------------------------------------
module pcw_front
    import pcw_pkg::*;
#(
    parameter int SIG_BYTES = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_word i_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_full,
    output t_cmd     o_cmd
);
    logic [2:0]  r_phase, n_phase;
    logic [30:0] r_cnt, n_cnt;
    logic [31:0] r_off;
    logic [30:0] r_len, n_len;
    logic [23:0] r_lacc, n_lacc;
    logic        take;
    logic [31:0] full_len;

    assign o_stall = i_cmd_full;
    assign take = i_valid && !i_cmd_full;
    assign o_cmd_valid = take;
    assign full_len = {r_lacc, i_word.data_byte};

    always_comb begin
        n_phase = r_phase;
        n_cnt = r_cnt + 31'd1;
        n_len = r_len;
        n_lacc = r_lacc;
        o_cmd = '0;
        o_cmd.data_byte = i_word.data_byte;
        o_cmd.phase = r_phase;
        o_cmd.offset = r_off;
        o_cmd.hdr_idx = r_cnt[3:0];
        o_cmd.hdr_cap = (r_phase == PH_DATA) && (r_cnt < 31'(HDR_BYTES));
        o_cmd.first = (r_phase == PH_LEN) && (r_cnt == 31'd0);
        unique case (r_phase)
            PH_SIG: begin
                if (r_cnt >= 31'(SIG_BYTES - 1)) begin
                    n_phase = PH_LEN;
                    n_cnt = '0;
                end
            end
            PH_LEN: begin
                n_lacc = o_cmd.first ? {16'd0, i_word.data_byte}
                                     : {r_lacc[15:0], i_word.data_byte};
                if (r_cnt == 31'd3) begin
                    n_len = full_len[31] ? MAX_LEN : full_len[30:0];
                    n_phase = PH_TYPE;
                    n_cnt = '0;
                end
            end
            PH_TYPE: begin
                if (r_cnt == 31'd3) begin
                    n_phase = (r_len != 31'd0) ? PH_DATA : PH_CRC;
                    n_cnt = '0;
                end
            end
            PH_DATA: begin
                if (r_cnt + 31'd1 >= r_len) begin
                    n_phase = PH_CRC;
                    n_cnt = '0;
                end
            end
            PH_CRC: begin
                if (r_cnt == 31'd3) begin
                    o_cmd.emit = 1'b1;
                    n_phase = PH_LEN;
                    n_cnt = '0;
                end
            end
            default: begin
                n_phase = PH_SIG;
                n_cnt = '0;
            end
        endcase
        o_cmd.trunc = i_word.last_byte && (r_phase != PH_SIG) && !o_cmd.emit;
        if (i_word.last_byte) begin
            n_phase = PH_SIG;
            n_cnt = '0;
            n_len = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_cnt <= '0;
            r_off <= '0;
            r_len <= '0;
            r_lacc <= '0;
        end else if (take) begin
            r_phase <= n_phase;
            r_cnt <= n_cnt;
            r_off <= i_word.last_byte ? 32'd0 : r_off + 32'd1;
            r_len <= n_len;
            r_lacc <= n_lacc;
        end
    end
endmodule

@@ design/pcw_fifo.sv @@
// ----------------------------------------------------------------------------
// pcw_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module pcw_fifo
    import pcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

@@ design/pcw_back.sv @@
// ----------------------------------------------------------------------------
// pcw_back
// crc, field assembly and output record register
// ----------------------------------------------------------------------------
module pcw_back
    import pcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_en,
    input  logic      i_cmd_valid,
    output logic      o_pop,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);
    logic [31:0] r_start, r_len, r_type, r_crc, r_rd;
    logic [7:0]  r_hdr [HDR_BYTES];
    logic        r_ovalid;
    t_out_word   r_out;
    logic [31:0] c_start, c_len, c_type, c_crc, c_rd;
    logic [7:0]  c_hdr [HDR_BYTES];
    logic        out_free, done, hdr;
    t_out_word   rec;

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop = i_cmd_valid && out_free;
    assign o_valid = r_ovalid;
    assign o_word = r_out;

    always_comb begin
        c_start = r_start; c_len = r_len; c_type = r_type; c_crc = r_crc; c_rd = r_rd;
        c_hdr = r_hdr;
        if (i_cmd.first) begin
            c_start = i_cmd.offset; c_len = '0; c_type = '0;
            c_crc = '1; c_rd = '0;
            for (int i = 0; i < HDR_BYTES; i++) c_hdr[i] = '0;
        end
        case (i_cmd.phase)
            PH_LEN:  c_len = {c_len[23:0], i_cmd.data_byte};
            PH_TYPE: begin
                c_crc = crc_byte(c_crc, i_cmd.data_byte);
                c_type = {c_type[23:0], i_cmd.data_byte};
            end
            PH_DATA: c_crc = crc_byte(c_crc, i_cmd.data_byte);
            PH_CRC:  c_rd = {c_rd[23:0], i_cmd.data_byte};
            default: ;
        endcase
        if (i_cmd.hdr_cap) c_hdr[i_cmd.hdr_idx] = i_cmd.data_byte;
        done = i_cmd.emit || i_cmd.trunc;
        hdr = i_cfg_en && (c_type == TYPE_IHDR);
        rec.chunk_offset = c_start;
        // saturation only visible once all four length bytes are in
        rec.chunk_length = c_len[31] ? MAX_LEN : c_len[30:0];
        rec.chunk_type = c_type;
        rec.crc_stored = c_rd;
        rec.crc_computed = ~c_crc;
        rec.crc_ok = !i_cmd.trunc && (c_rd == ~c_crc);
        rec.image_width = hdr ? {c_hdr[0], c_hdr[1], c_hdr[2], c_hdr[3]} : '0;
        rec.image_height = hdr ? {c_hdr[4], c_hdr[5], c_hdr[6], c_hdr[7]} : '0;
        rec.bit_depth = hdr ? c_hdr[8] : '0;
        rec.color_type = hdr ? c_hdr[9] : '0;
        rec.ihdr_methods = hdr ? {c_hdr[10], c_hdr[11], c_hdr[12]} : '0;
        rec.truncated = i_cmd.trunc;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start <= c_start; r_len <= c_len; r_type <= c_type;
            r_crc <= c_crc; r_rd <= c_rd; r_hdr <= c_hdr;
            if (done) r_out <= rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= o_pop && done;
        end
    end
endmodule

@@ design/png_chunk_walker_crc_check.sv @@
// ----------------------------------------------------------------------------
// png_chunk_walker_crc_check
// walks png chunks from a byte stream and checks each chunk crc-32
// ----------------------------------------------------------------------------
// one byte word per clock sustained while the queue has room; the front tracks
// phase and field counts and feeds a two-entry command queue, the back runs a
// one-byte-per-cycle crc-32 update while its output is free and assembles
// the record into an output register, so a held output stalls the input
// only once the queue fills; each record passes the queue and output register.
module png_chunk_walker_crc_check
    import pcw_pkg::*;
#(
    parameter int SIGNATURE_BYTES = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);
`include "png_chunk_walker_crc_check_macros.svh"

    logic r_cfg_en;
    logic cmd_push, q_full, q_valid, q_pop;
    t_cmd f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;
    // header decode enable, sampled when a record is formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg_en <= 1'b0;
        else if (i_cfg_valid) r_cfg_en <= i_cfg_data;
    end

    pcw_front #(.SIG_BYTES(SIGNATURE_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word,
        .o_cmd_valid(cmd_push), .i_cmd_full(q_full), .o_cmd(f_cmd)
    );

    pcw_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(cmd_push), .i_cmd(f_cmd), .o_full(q_full),
        .o_valid(q_valid), .i_pop(q_pop), .o_cmd(q_cmd)
    );

    pcw_back u_back (
        .i_clk, .i_rst_n, .i_cfg_en(r_cfg_en), .i_cmd_valid(q_valid), .o_pop(q_pop),
        .i_cmd(q_cmd), .o_valid, .i_stall, .o_word
    );

    `PCW_ASSERT(a_no_pop_empty, !(q_pop && !q_valid), "pop from empty queue")
    `PCW_ASSERT(a_ok_not_trunc, !(o_valid && o_word.crc_ok && o_word.truncated), "crc ok on truncated record")
    `PCW_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_word), "held record changed")
endmodule
